// ----- src/pwmdw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pwmdw_pkg;

	localparam int CHAN_COUNT = 8;
	localparam logic [31:0] CLK_RESET = 32'd125000000;
	localparam logic [11:0] D_FIRST = 12'd16;
	localparam logic [11:0] D_LAST = 12'd4095;
	localparam logic [15:0] DEF_TOP = 16'd255;
	localparam logic [16:0] FULL_DUTY = 17'd65536;
	localparam int N_W = 44;
	localparam int DIV_W = 46;
	localparam int DIV_Q_W = 40;
	localparam int MUL_A_W = 46;
	localparam int MUL_B_W = 28;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam logic [5:0] TOP_STEPS = 6'd17;
	localparam logic [5:0] FREQ_STEPS = 6'd40;
	localparam logic [MUL_B_W-1:0] STOP_SCALE = 28'd1000000;
	localparam logic [34:0] FREQ_MAX = 35'h7FFFFFFFF;

	typedef struct packed {
		logic [3:0]  channel_index;
		logic [34:0] target_freq_q8;
		logic [16:0] duty_q16;
	} in_t;

	typedef struct packed {
		logic        accepted;
		logic        running;
		logic [15:0] wrap_top;
		logic [7:0]  divider_int;
		logic [3:0]  divider_frac;
		logic [16:0] compare_level;
		logic [16:0] applied_duty_q16;
		logic [34:0] achieved_freq_q8;
	} out_t;

	typedef struct packed {
		logic load;
		logic den;
		logic div_top;
		logic top;
		logic prod;
		logic err;
		logic take;
		logic mul_eb;
		logic hold_p1;
		logic mul_bm;
		logic mul_stop;
		logic next_d;
		logic fin_a;
		logic div_freq;
		logic fin_b;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic chan_ok;
		logic f_zero;
		logic in_range;
		logic have;
		logic d_last;
		logic div_done;
		logic mul_done;
		logic better;
		logic stop;
	} sts_t;

endpackage
`default_nettype wire

// ----- src/pwmdw_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pwmdw_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [5:0]                         steps,
	input  wire logic [pwmdw_pkg::DIV_W-1:0]        dividend,
	input  wire logic [pwmdw_pkg::DIV_W-1:0]        divisor,
	output logic                                    done,
	output logic [pwmdw_pkg::DIV_Q_W-1:0]           quot
);

	logic [pwmdw_pkg::DIV_W-1:0] rem_q;
	logic [pwmdw_pkg::DIV_W-1:0] pend_q;
	logic [pwmdw_pkg::DIV_W-1:0] dsr_q;
	logic [pwmdw_pkg::DIV_Q_W-1:0] quot_q;
	logic [5:0] cnt_q;
	logic done_q;
	logic [pwmdw_pkg::DIV_W:0] trial;
	logic [pwmdw_pkg::DIV_W:0] diff;
	logic fits;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, pend_q[pwmdw_pkg::DIV_W-1]};
		diff = trial - {1'b0, dsr_q};
		fits = trial >= {1'b0, dsr_q};
	end

	// control: count steps, flag the finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) done_q <= 1'b1;
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend >> steps;
			pend_q <= dividend << (6'(pwmdw_pkg::DIV_W) - steps);
			dsr_q <= divisor;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[pwmdw_pkg::DIV_W-1:0] : trial[pwmdw_pkg::DIV_W-1:0];
			pend_q <= pend_q << 1;
			quot_q <= {quot_q[pwmdw_pkg::DIV_Q_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

// ----- src/pwmdw_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pwmdw_mul (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [pwmdw_pkg::MUL_A_W-1:0]      a,
	input  wire logic [pwmdw_pkg::MUL_B_W-1:0]      b,
	output logic                                    done,
	output logic [pwmdw_pkg::MUL_P_W-1:0]           prod
);

	logic [pwmdw_pkg::MUL_P_W-1:0] acc_q;
	logic [pwmdw_pkg::MUL_P_W-1:0] ash_q;
	logic [pwmdw_pkg::MUL_B_W-1:0] bsh_q;
	logic [4:0] cnt_q;
	logic done_q;

	// control: one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 5'(pwmdw_pkg::MUL_B_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) done_q <= 1'b1;
			end
		end
	end

	// shift and add
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			ash_q <= {{pwmdw_pkg::MUL_B_W{1'b0}}, a};
			bsh_q <= b;
		end else if (cnt_q != '0) begin
			if (bsh_q[0]) acc_q <= acc_q + ash_q;
			ash_q <= ash_q << 1;
			bsh_q <= bsh_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

// ----- src/pwmdw_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pwmdw_dpath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	input  wire pwmdw_pkg::in_t    in_data,
	input  wire pwmdw_pkg::cmd_t   cmd,
	output pwmdw_pkg::sts_t        sts,
	output pwmdw_pkg::out_t        out_data
);

	logic [31:0] clk_hz_q;
	pwmdw_pkg::in_t in_q;
	logic [16:0] duty_q;
	logic [11:0] d_q;
	logic [46:0] den_q;
	logic [16:0] p_q;
	logic [15:0] top_q;
	logic [27:0] m_q;
	logic [45:0] fdp_q;
	logic [45:0] e_q;
	logic have_q;
	logic [45:0] best_e_q;
	logic [27:0] best_m_q;
	logic [15:0] win_top_q;
	logic [11:0] best_d_q;
	logic [pwmdw_pkg::MUL_P_W-1:0] p1_q;
	logic [16:0] fp_q;
	logic [32:0] lvl_q;
	logic [28:0] dp_q;
	logic [16:0] level_q;
	logic [34:0] freq_q;
	pwmdw_pkg::out_t out_q;
	pwmdw_pkg::out_t out_d;

	logic [pwmdw_pkg::N_W-1:0] n;
	logic [62:0] den_hi;
	logic div_start;
	logic [5:0] div_steps;
	logic [pwmdw_pkg::DIV_W-1:0] div_a;
	logic [pwmdw_pkg::DIV_W-1:0] div_b;
	logic div_done;
	logic [pwmdw_pkg::DIV_Q_W-1:0] quot;
	logic mul_start;
	logic [pwmdw_pkg::MUL_A_W-1:0] mul_a;
	logic [pwmdw_pkg::MUL_B_W-1:0] mul_b;
	logic mul_done;
	logic [pwmdw_pkg::MUL_P_W-1:0] mul_p;
	logic [16:0] lvl_sh;
	logic [45:0] n_w;

	assign n = {clk_hz_q, 12'd0};
	assign n_w = {2'b00, n};
	assign den_hi = {den_q, 16'd0};

	// hold the clock register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clk_hz_q <= pwmdw_pkg::CLK_RESET;
		else if (cfg_we) clk_hz_q <= cfg_wdata;
	end

	// select divider operands
	always_comb begin
		div_start = cmd.div_top | cmd.div_freq;
		if (cmd.div_freq) begin
			div_steps = pwmdw_pkg::FREQ_STEPS;
			div_a = {n_w[44:0], 1'b0} + 46'(dp_q);
			div_b = 46'({dp_q, 1'b0});
		end else begin
			div_steps = pwmdw_pkg::TOP_STEPS;
			div_a = {n_w[44:0], 1'b0} + den_q[45:0];
			div_b = {den_q[44:0], 1'b0};
		end
	end

	// select multiplier operands
	always_comb begin
		mul_start = cmd.mul_eb | cmd.mul_bm | cmd.mul_stop;
		if (cmd.mul_bm) begin
			mul_a = best_e_q;
			mul_b = m_q;
		end else if (cmd.mul_eb) begin
			mul_a = e_q;
			mul_b = best_m_q;
		end else begin
			mul_a = e_q;
			mul_b = pwmdw_pkg::STOP_SCALE;
		end
	end

	pwmdw_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .steps(div_steps),
		.dividend(div_a), .divisor(div_b), .done(div_done), .quot(quot)
	);

	pwmdw_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	// candidate search registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.load) begin
			have_q <= 1'b0;
		end else if (cmd.take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
			duty_q <= (in_data.duty_q16 > pwmdw_pkg::FULL_DUTY) ?
				pwmdw_pkg::FULL_DUTY : in_data.duty_q16;
			d_q <= pwmdw_pkg::D_FIRST;
			win_top_q <= pwmdw_pkg::DEF_TOP;
			best_d_q <= pwmdw_pkg::D_FIRST;
		end
		if (cmd.den) den_q <= 47'(in_q.target_freq_q8 * d_q);
		if (cmd.top) begin
			p_q <= (quot[16:0] <= 17'd1) ? 17'd2 : quot[16:0];
			top_q <= (quot[16:0] <= 17'd1) ? 16'd1 : 16'(quot[16:0] - 17'd1);
		end
		if (cmd.prod) begin
			m_q <= 28'(d_q * p_q);
			fdp_q <= 46'(den_q[43:0] * p_q);
		end
		if (cmd.err) e_q <= (n_w > fdp_q) ? n_w - fdp_q : fdp_q - n_w;
		if (cmd.take) begin
			best_e_q <= e_q;
			best_m_q <= m_q;
			win_top_q <= top_q;
			best_d_q <= d_q;
		end
		if (cmd.hold_p1) p1_q <= mul_p;
		if (cmd.next_d) d_q <= d_q + 12'd1;
		if (cmd.fin_a) begin
			fp_q <= 17'({1'b0, win_top_q} + 17'd1);
			lvl_q <= 33'(({1'b0, win_top_q} + 17'd1) * duty_q) + 33'd32768;
			dp_q <= 29'(best_d_q * ({1'b0, win_top_q} + 17'd1));
		end
		if (cmd.fin_b) begin
			level_q <= (lvl_sh > fp_q) ? fp_q : lvl_sh;
			freq_q <= (quot > 40'(pwmdw_pkg::FREQ_MAX)) ? pwmdw_pkg::FREQ_MAX : quot[34:0];
		end
	end

	assign lvl_sh = lvl_q[32:16];

	// build the result
	always_comb begin
		out_d = '0;
		if (sts.chan_ok) begin
			out_d.accepted = 1'b1;
			out_d.applied_duty_q16 = duty_q;
			if (sts.f_zero) begin
				out_d.wrap_top = pwmdw_pkg::DEF_TOP;
				out_d.divider_int = 8'd1;
			end else begin
				out_d.running = 1'b1;
				out_d.wrap_top = win_top_q;
				out_d.divider_int = best_d_q[11:4];
				out_d.divider_frac = best_d_q[3:0];
				out_d.compare_level = level_q;
				out_d.achieved_freq_q8 = freq_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_q <= out_d;
	end

	// status to the controller
	always_comb begin
		sts.chan_ok = 32'(in_q.channel_index) < pwmdw_pkg::CHAN_COUNT;
		sts.f_zero = in_q.target_freq_q8 == '0;
		sts.in_range = (47'(n) >= den_q) && (63'(n) <= den_hi);
		sts.have = have_q;
		sts.d_last = d_q == pwmdw_pkg::D_LAST;
		sts.div_done = div_done;
		sts.mul_done = mul_done;
		sts.better = p1_q < mul_p;
		sts.stop = mul_p < 74'(fdp_q);
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

// ----- src/pwmdw_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pwmdw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_stall,
	input  wire pwmdw_pkg::sts_t   sts,
	output pwmdw_pkg::cmd_t        cmd,
	output logic                   in_stall,
	output logic                   out_valid
);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_DEN, S_CHK, S_DIV, S_PROD, S_ERR, S_EVAL,
		S_M1, S_M2, S_M3, S_NEXT, S_FIN_A, S_FIN_DIV, S_FIN_WAIT, S_OUT
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: state_d = (!sts.chan_ok || sts.f_zero) ? S_OUT : S_DEN;
			S_DEN: begin
				cmd.den = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.in_range) begin
					cmd.div_top = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.top = 1'b1;
					state_d = S_PROD;
				end
			end
			S_PROD: begin
				cmd.prod = 1'b1;
				state_d = S_ERR;
			end
			S_ERR: begin
				cmd.err = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (!sts.have) begin
					cmd.take = 1'b1;
					cmd.mul_stop = 1'b1;
					state_d = S_M3;
				end else begin
					cmd.mul_eb = 1'b1;
					state_d = S_M1;
				end
			end
			S_M1: begin
				if (sts.mul_done) begin
					cmd.hold_p1 = 1'b1;
					cmd.mul_bm = 1'b1;
					state_d = S_M2;
				end
			end
			S_M2: begin
				if (sts.mul_done) begin
					if (sts.better) begin
						cmd.take = 1'b1;
						cmd.mul_stop = 1'b1;
						state_d = S_M3;
					end else begin
						state_d = S_NEXT;
					end
				end
			end
			S_M3: begin
				if (sts.mul_done) state_d = sts.stop ? S_FIN_A : S_NEXT;
			end
			S_NEXT: begin
				if (sts.d_last) begin
					state_d = S_FIN_A;
				end else begin
					cmd.next_d = 1'b1;
					state_d = S_DEN;
				end
			end
			S_FIN_A: begin
				cmd.fin_a = 1'b1;
				state_d = S_FIN_DIV;
			end
			S_FIN_DIV: begin
				cmd.div_freq = 1'b1;
				state_d = S_FIN_WAIT;
			end
			S_FIN_WAIT: begin
				if (sts.div_done) begin
					cmd.fin_b = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- src/pwm_divider_wrap_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Flow: a rejected or disabled request goes from decode straight to the result. A search
// skips a divider that does not fit; for a fitting one it runs the top division and two
// products, a third on a new best, one alone on the first fit, over up to 4080 dividers,
// then the final frequency division.
// Throughput: one request at a time; the next is taken once the result is queued.
// Reset: arst_n clears the controller and loads the clock register to 125 MHz.
module pwm_divider_wrap_search (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire pwmdw_pkg::in_t    in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output pwmdw_pkg::out_t        out_data
);

	pwmdw_pkg::cmd_t cmd;
	pwmdw_pkg::sts_t sts;

	pwmdw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd), .in_stall(in_stall), .out_valid(out_valid)
	);

	pwmdw_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_data(in_data), .cmd(cmd), .sts(sts), .out_data(out_data)
	);

endmodule
`default_nettype wire

// ----- tb/pwm_divider_wrap_search_tb.sv -----
`timescale 1ns / 1ps
module pwm_divider_wrap_search_tb;

	localparam longint CYCLE_LIMIT = 8_000_000;
	localparam int LONG_HOLD = 400;
	localparam logic [63:0] FREQ_CAP = 64'h7FFFFFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	pwmdw_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pwmdw_pkg::out_t out_data;

	pwmdw_pkg::in_t pending_reqs[$];
	pwmdw_pkg::out_t expected_settings[$];
	logic [63:0] model_clock_hz = 64'd125000000;
	int mismatches = 0;
	longint cycle_count = 0;
	logic took_req = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int stall_mode = 0;
	int stall_age = 0;

	pwm_divider_wrap_search DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the divider, wrap top and levels the block should settle on
	function automatic pwmdw_pkg::out_t predict_setting(pwmdw_pkg::in_t req);
		pwmdw_pkg::out_t r;
		logic [63:0] n, f, duty, win_top, best_d, best_e, best_m;
		logic [63:0] d, den, top, m, fdp, e, p, level, dp, freq;
		logic [127:0] lhs, rhs;
		bit have, done;
		r = '0;
		have = 0;
		done = 0;
		if (req.channel_index >= pwmdw_pkg::CHAN_COUNT)
			return r;
		r.accepted = 1'b1;
		duty = req.duty_q16;
		if (duty > pwmdw_pkg::FULL_DUTY)
			duty = pwmdw_pkg::FULL_DUTY;
		r.applied_duty_q16 = duty[16:0];
		f = req.target_freq_q8;
		n = model_clock_hz * 64'd4096;
		if (f == 0) begin
			r.wrap_top = pwmdw_pkg::DEF_TOP;
			r.divider_int = 8'd1;
			return r;
		end
		win_top = pwmdw_pkg::DEF_TOP;
		best_d = 16;
		best_e = 0;
		best_m = 1;
		for (int ii = 1; ii <= 255 && !done; ii++) begin
			for (int fr = 0; fr < 16 && !done; fr++) begin
				d = ii * 16 + fr;
				den = f * d;
				if (n < den || n > den * 64'd65536)
					continue;
				top = (2 * n + den) / (2 * den);
				top = (top >= 1) ? top - 1 : 0;
				if (top < 1)
					top = 1;
				if (top > 65535)
					continue;
				m = d * (top + 1);
				fdp = f * m;
				e = (n > fdp) ? n - fdp : fdp - n;
				lhs = 128'(e) * 128'(best_m);
				rhs = 128'(best_e) * 128'(m);
				if (!have || lhs < rhs) begin
					have = 1;
					best_e = e;
					best_m = m;
					win_top = top;
					best_d = d;
					// stop once the error is below one part per million
					if (128'(e) * 128'd1000000 < 128'(fdp))
						done = 1;
				end
			end
		end
		p = win_top + 1;
		if (duty == 0)
			level = 0;
		else if (duty >= pwmdw_pkg::FULL_DUTY)
			level = p;
		else begin
			level = (p * duty + 64'd32768) >> 16;
			if (level > p)
				level = p;
		end
		dp = best_d * p;
		freq = (2 * n + dp) / (2 * dp);
		if (freq > FREQ_CAP)
			freq = FREQ_CAP;
		r.running = 1'b1;
		r.wrap_top = win_top[15:0];
		r.divider_int = best_d[11:4];
		r.divider_frac = best_d[3:0];
		r.compare_level = level[16:0];
		r.achieved_freq_q8 = freq[34:0];
		return r;
	endfunction

	// Build a request whose target is hit exactly by a small divider, so the search ends early
	function automatic pwmdw_pkg::in_t exact_hit_req(logic [3:0] chan, logic [16:0] duty);
		pwmdw_pkg::in_t r;
		logic [63:0] n, dd, pp, ff;
		r.channel_index = chan;
		r.duty_q16 = duty;
		n = model_clock_hz * 64'd4096;
		ff = n / 64'd4096;
		for (int t = 0; t < 400; t++) begin
			dd = $urandom_range(16, 47);
			if ($urandom_range(0, 1))
				pp = 64'd1 << $urandom_range(1, 16);
			else
				pp = $urandom_range(2, 65536);
			if (n % (dd * pp) == 0 && n / (dd * pp) <= FREQ_CAP) begin
				ff = n / (dd * pp);
				break;
			end
		end
		r.target_freq_q8 = ff[34:0];
		return r;
	endfunction

	function automatic pwmdw_pkg::in_t fast_req();
		pwmdw_pkg::in_t r;
		r.duty_q16 = 17'($urandom_range(0, 131071));
		r.target_freq_q8 = {3'($urandom_range(0, 7)), $urandom()};
		if ($urandom_range(0, 1)) begin
			r.channel_index = 4'($urandom_range(pwmdw_pkg::CHAN_COUNT, 15));
		end else begin
			r.channel_index = 4'($urandom_range(0, pwmdw_pkg::CHAN_COUNT - 1));
			r.target_freq_q8 = '0;
		end
		return r;
	endfunction

	function automatic pwmdw_pkg::in_t make_req(logic [3:0] chan, logic [34:0] freq,
		logic [16:0] duty);
		pwmdw_pkg::in_t r;
		r.channel_index = chan;
		r.target_freq_q8 = freq;
		r.duty_q16 = duty;
		return r;
	endfunction

	// Mostly exact-hit requests, some fast ones, a rare very high target
	task automatic queue_random(int count);
		int pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				pending_reqs.push_back(fast_req());
			else if (pick < 28)
				pending_reqs.push_back(make_req(4'($urandom_range(0, pwmdw_pkg::CHAN_COUNT - 1)),
					{3'b111, $urandom()}, 17'($urandom_range(0, 131071))));
			else
				pending_reqs.push_back(exact_hit_req(
					4'($urandom_range(0, pwmdw_pkg::CHAN_COUNT - 1)),
					17'($urandom_range(0, 131071))));
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_settings.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_clock(logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_clock_hz = value;
	endtask

	task automatic flag_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		$display("%0t: %s expected %0d got %0d", $realtime, name, exp_v, got_v);
		mismatches++;
	endtask

	// Accept requests and record what each should produce
	always @(posedge clk) begin
		took_req <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			expected_settings.push_back(predict_setting(in_data));
	end

	// Check each delivered result against the oldest expectation
	always @(posedge clk) begin
		pwmdw_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_settings.size() == 0) begin
				$display("%0t: unexpected result, expected none got %h", $realtime, out_data);
				mismatches++;
			end else begin
				want = expected_settings.pop_front();
				if (out_data.accepted !== want.accepted)
					flag_field("accepted", want.accepted, out_data.accepted);
				if (out_data.running !== want.running)
					flag_field("running", want.running, out_data.running);
				if (out_data.wrap_top !== want.wrap_top)
					flag_field("wrap_top", want.wrap_top, out_data.wrap_top);
				if (out_data.divider_int !== want.divider_int)
					flag_field("divider_int", want.divider_int, out_data.divider_int);
				if (out_data.divider_frac !== want.divider_frac)
					flag_field("divider_frac", want.divider_frac, out_data.divider_frac);
				if (out_data.compare_level !== want.compare_level)
					flag_field("compare_level", want.compare_level, out_data.compare_level);
				if (out_data.applied_duty_q16 !== want.applied_duty_q16)
					flag_field("applied_duty_q16", want.applied_duty_q16,
						out_data.applied_duty_q16);
				if (out_data.achieved_freq_q8 !== want.achieved_freq_q8)
					flag_field("achieved_freq_q8", want.achieved_freq_q8,
						out_data.achieved_freq_q8);
			end
		end
	end

	// Offer requests in bursts with random gaps; hold a stalled request steady
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || took_req) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= pending_reqs.pop_front();
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 8);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side on its own pattern, with one long hold when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			if (stall_age == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_age <= $urandom_range(16, 96);
			end else begin
				stall_age <= stall_age - 1;
			end
			out_stall <= (stall_mode != 0) && ($urandom_range(0, 3) < stall_mode);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [63:0] n;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset clock: field extremes, disable, rejection, duty clamps, no-fit
		n = model_clock_hz * 64'd4096;
		pending_reqs.push_back(make_req(4'd0, 35'd0, 17'd0));
		pending_reqs.push_back(make_req(4'd7, 35'd0, 17'd131071));
		pending_reqs.push_back(make_req(4'd8, 35'h7FFFFFFFF, 17'd131071));
		pending_reqs.push_back(make_req(4'd15, 35'h5A5A5A5A5, 17'd65536));
		pending_reqs.push_back(make_req(4'd1, 35'h7FFFFFFFF, 17'd65536));
		pending_reqs.push_back(make_req(4'd2, 35'd1, 17'd1));
		pending_reqs.push_back(make_req(4'd3, 35'(n / 32), 17'd65536));
		pending_reqs.push_back(make_req(4'd4, 35'(n / 32), 17'd65537));
		pending_reqs.push_back(make_req(4'd5, 35'd390625, 17'd32768));
		pending_reqs.push_back(make_req(4'd6, 35'd390625, 17'd0));
		pending_reqs.push_back(make_req(4'd0, 35'd1280000, 17'd32767));
		pending_reqs.push_back(make_req(4'd7, 35'd25600000, 17'd12345));
		pending_reqs.push_back(exact_hit_req(4'd3, 17'd65535));
		queue_random(30);
		drain();

		// Slowest clock
		write_clock(32'd1);
		pending_reqs.push_back(make_req(4'd0, 35'd128, 17'd40000));
		pending_reqs.push_back(make_req(4'd1, 35'd2, 17'd65536));
		queue_random(15);
		drain();

		// Fastest clock
		write_clock(32'hFFFFFFFF);
		pending_reqs.push_back(make_req(4'd2, 35'h7FFFFFFFF, 17'd20000));
		queue_random(20);
		drain();

		// Random clock; fill the block behind a long receiver hold first
		write_clock($urandom_range(1000000, 200000000));
		for (int k = 0; k < 12; k++)
			pending_reqs.push_back(fast_req());
		hold_go <= 1'b1;
		queue_random(15);
		drain();

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
